FILE: rtl/core/thermistor_resistance_to_celsius_assert.svh
// Assertion macros used by the checker file.
`ifndef THERMISTOR_RESISTANCE_TO_CELSIUS_ASSERT_SVH
`define THERMISTOR_RESISTANCE_TO_CELSIUS_ASSERT_SVH
// Same-cycle implication, disabled during reset.
`define TRC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("thermistor checker: same-cycle property failed");
// Next-cycle implication, disabled during reset.
`define TRC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("thermistor checker: next-cycle property failed");
`endif

FILE: rtl/core/trc_pkg.sv
// Types and constants shared by the thermistor conversion pipeline.
`default_nettype none
package trc_pkg;
  localparam int FRAC_BITS = 28;
  localparam int L_W = 29;
  localparam int D_W = 40;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [14:0] KELVIN_X100 = 15'd27315;
  localparam logic [31:0] RESET_A = 32'd1241511355;
  localparam logic [31:0] RESET_B = 32'd257423160;
  localparam logic [31:0] RESET_C = 32'd394849070;
  localparam logic [1:0] REG_A = 2'd0;
  localparam logic [1:0] REG_B = 2'd1;
  localparam logic [1:0] REG_C = 2'd2;

  typedef struct packed {
    logic valid;
    logic invalid;
  } tag_t;
endpackage
`default_nettype wire

FILE: rtl/core/trc_log.sv
// Natural logarithm pipeline: normalize, one squaring step per stage, scale by ln 2.
`default_nettype none
module trc_log import trc_pkg::*; #(
  parameter int RESIST_BITS = 22
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tag_t                   in_tag,
  input  logic [RESIST_BITS-1:0] r,
  output tag_t                   out_tag,
  output logic [L_W-1:0]         ln_q24
);
  tag_t                 tag_s [0:FRAC_BITS];
  logic [31:0]          m_s   [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] lg_s  [0:FRAC_BITS];
  logic [4:0]           k_s   [0:FRAC_BITS];
  logic [4:0]           k_c;
  logic [31:0]          m_c;
  logic [32:0]          lg_full;
  logic [62:0]          ln_prod;
  tag_t                 tag_o;

  always_comb begin
    k_c = 5'd0;
    for (int i = 0; i < RESIST_BITS; i++) begin
      if (r[i]) k_c = 5'(i);
    end
    m_c = 32'(r) << (5'd31 - k_c);
  end

  always_ff @(posedge clk) begin
    if (rst) tag_s[0].valid <= 1'b0;
    else tag_s[0] <= in_tag;
    m_s[0]  <= m_c;
    k_s[0]  <= k_c;
    lg_s[0] <= '0;
  end

  for (genvar g = 0; g < FRAC_BITS; g++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] mm;
    assign sq = 64'(m_s[g]) * 64'(m_s[g]);
    assign mm = sq[63:31];
    always_ff @(posedge clk) begin
      if (rst) tag_s[g+1].valid <= 1'b0;
      else tag_s[g+1] <= tag_s[g];
      m_s[g+1]  <= mm[32] ? mm[32:1] : mm[31:0];
      lg_s[g+1] <= {lg_s[g][FRAC_BITS-2:0], mm[32]};
      k_s[g+1]  <= k_s[g];
    end
  end

  assign lg_full = {k_s[FRAC_BITS], lg_s[FRAC_BITS]};
  assign ln_prod = 63'(lg_full) * 63'(LN2_Q30);

  always_ff @(posedge clk) begin
    if (rst) tag_o.valid <= 1'b0;
    else tag_o <= tag_s[FRAC_BITS];
    ln_q24 <= ln_prod[62:34];
  end

  assign out_tag = tag_o;
endmodule
`default_nettype wire

FILE: rtl/core/trc_poly.sv
// Steinhart-Hart denominator A + B*L + C*L^3 over five register stages.
`default_nettype none
module trc_poly import trc_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic [31:0]    coef_a,
  input  logic [31:0]    coef_b,
  input  logic [31:0]    coef_c,
  input  tag_t           in_tag,
  input  logic [L_W-1:0] ln_q24,
  output tag_t           out_tag,
  output logic [D_W-1:0] d
);
  tag_t        t1, t2, t3, t4, t5;
  logic [L_W-1:0] l1;
  logic [33:0] l2_1;
  logic [38:0] l3_2;
  logic [36:0] bt_2, bt_3;
  logic [50:0] chp_3;
  logic [31:0] cls_3;
  logic [35:0] cterm_4;
  logic [37:0] ab_4;
  logic [57:0] p1;
  logic [62:0] p2;
  logic [60:0] pb;
  logic [51:0] pcl;
  logic [51:0] csum;

  assign p1   = 58'(ln_q24) * 58'(ln_q24);
  assign p2   = 63'(l2_1) * 63'(l1);
  assign pb   = 61'(coef_b) * 61'(l1);
  assign pcl  = 52'(coef_c) * 52'(l3_2[19:0]);
  assign csum = 52'(chp_3) + 52'(cls_3);

  always_ff @(posedge clk) begin
    if (rst) begin
      t1.valid <= 1'b0;
      t2.valid <= 1'b0;
      t3.valid <= 1'b0;
      t4.valid <= 1'b0;
      t5.valid <= 1'b0;
    end else begin
      t1 <= in_tag;
      t2 <= t1;
      t3 <= t2;
      t4 <= t3;
      t5 <= t4;
    end
    l1      <= ln_q24;
    l2_1    <= p1[57:24];
    l3_2    <= p2[62:24];
    bt_2    <= pb[60:24];
    chp_3   <= 51'(coef_c) * 51'(l3_2[38:20]);
    cls_3   <= pcl[51:20];
    bt_3    <= bt_2;
    cterm_4 <= csum[51:16];
    ab_4    <= 38'(coef_a) + 38'(bt_3);
    d       <= 40'(ab_4) + 40'(cterm_4);
  end

  assign out_tag = t5;
endmodule
`default_nettype wire

FILE: rtl/core/trc_div.sv
// Kelvin offset, restoring division to whole degrees, scaling and saturation.
`default_nettype none
module trc_div import trc_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  tag_t           in_tag,
  input  logic [D_W-1:0] d,
  output logic           done,
  output logic [15:0]    temp_c_x100,
  output logic           invalid_input,
  output logic           saturated
);
  localparam int QB = 10;
  localparam logic [55:0] NUM_K = 56'd100 << 40;
  localparam logic [QB-1:0] SAT_Q = QB'(328);

  tag_t        t0;
  logic [55:0] kd_0;
  logic [46:0] den_0;
  logic        zero_0;
  tag_t        tq   [0:QB];
  logic [55:0] rem  [0:QB];
  logic [46:0] den  [0:QB];
  logic [QB-1:0] q  [0:QB];
  logic        neg  [0:QB];
  logic        zero [0:QB];
  logic [15:0] mag_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      t0.valid <= 1'b0;
      tq[0].valid <= 1'b0;
    end else begin
      t0 <= in_tag;
      tq[0] <= t0;
    end
    kd_0    <= 56'(d) * 56'(KELVIN_X100);
    den_0   <= 47'(d) * 47'd100;
    zero_0  <= (d == '0);
    // The numerator 100*2^40 - 27315*D is split into sign and magnitude.
    neg[0]  <= kd_0 > NUM_K;
    rem[0]  <= (kd_0 > NUM_K) ? kd_0 - NUM_K : NUM_K - kd_0;
    den[0]  <= den_0;
    zero[0] <= zero_0;
    q[0]    <= '0;
  end

  for (genvar g = 0; g < QB; g++) begin : g_div
    logic [56:0] trial;
    logic        fits;
    assign trial = 57'(den[g]) << (QB - 1 - g);
    assign fits  = 57'(rem[g]) >= trial;
    always_ff @(posedge clk) begin
      if (rst) tq[g+1].valid <= 1'b0;
      else tq[g+1] <= tq[g];
      rem[g+1]  <= fits ? 56'(57'(rem[g]) - trial) : rem[g];
      q[g+1]    <= {q[g][QB-2:0], fits};
      den[g+1]  <= den[g];
      neg[g+1]  <= neg[g];
      zero[g+1] <= zero[g];
    end
  end

  assign mag_t = 16'(q[QB]) * 16'd100;

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= tq[QB].valid;
    invalid_input <= tq[QB].invalid;
    if (tq[QB].invalid) begin
      temp_c_x100 <= '0;
      saturated   <= 1'b0;
    end else if (zero[QB]) begin
      // A zero denominator means an unbounded temperature.
      temp_c_x100 <= 16'h7FFF;
      saturated   <= 1'b1;
    end else if (q[QB] >= SAT_Q) begin
      temp_c_x100 <= neg[QB] ? 16'h8000 : 16'h7FFF;
      saturated   <= 1'b1;
    end else begin
      temp_c_x100 <= neg[QB] ? 16'(-mag_t) : mag_t;
      saturated   <= 1'b0;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/thermistor_resistance_to_celsius.sv
// An accepted start reaches its done beat through the log, polynomial and divide pipelines in turn.
// Throughput: one sample per cycle; busy is always low and results cannot be held off.
// The squaring steps of the logarithm and the quotient bits of the divider set the depth.
// Reset (rst, synchronous) clears all stage valid bits and loads the coefficient reset values.
`default_nettype none
module thermistor_resistance_to_celsius import trc_pkg::*; #(
  parameter int RESIST_BITS = 22
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [RESIST_BITS-1:0] resistance_ohms,
  output logic                   done,
  output logic signed [15:0]     temp_c_x100,
  output logic                   invalid_input,
  output logic                   saturated,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  logic [31:0]    coef_a, coef_b, coef_c;
  tag_t           in_tag, log_tag, poly_tag;
  logic [L_W-1:0] ln_q24;
  logic [D_W-1:0] d;
  logic [15:0]    temp_raw;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign in_tag = '{valid: start, invalid: (resistance_ohms == '0)};

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a <= RESET_A;
      coef_b <= RESET_B;
      coef_c <= RESET_C;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_A:   coef_a <= pwdata;
        REG_B:   coef_b <= pwdata;
        REG_C:   coef_c <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_A:   prdata = coef_a;
      REG_B:   prdata = coef_b;
      REG_C:   prdata = coef_c;
      default: prdata = '0;
    endcase
  end

  trc_log #(.RESIST_BITS(RESIST_BITS)) u_log (
    .clk(clk), .rst(rst), .in_tag(in_tag), .r(resistance_ohms),
    .out_tag(log_tag), .ln_q24(ln_q24)
  );

  trc_poly u_poly (
    .clk(clk), .rst(rst), .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
    .in_tag(log_tag), .ln_q24(ln_q24), .out_tag(poly_tag), .d(d)
  );

  trc_div u_div (
    .clk(clk), .rst(rst), .in_tag(poly_tag), .d(d), .done(done),
    .temp_c_x100(temp_raw), .invalid_input(invalid_input), .saturated(saturated)
  );

  assign temp_c_x100 = $signed(temp_raw);
endmodule
`default_nettype wire

FILE: rtl/core/trc_chk.sv
// Port-level checker for the thermistor conversion block, with its bind.
`default_nettype none
`include "thermistor_resistance_to_celsius_assert.svh"
module trc_chk #(
  parameter int LATENCY = 48
) (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [15:0] temp_c_x100,
  input logic        invalid_input,
  input logic        saturated
);
  `TRC_ASSERT_NXT(a_never_busy, 1'b1, !busy)
  `TRC_ASSERT_IMP(a_invalid_form, done && invalid_input, temp_c_x100 == 16'h0 && !saturated)
  `TRC_ASSERT_IMP(a_sat_bound, done && saturated, temp_c_x100 == 16'h7FFF || temp_c_x100 == 16'h8000)
  `TRC_ASSERT_IMP(a_beat_latency, start && !busy, ##LATENCY done)
endmodule

bind thermistor_resistance_to_celsius trc_chk u_trc_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .temp_c_x100(temp_c_x100), .invalid_input(invalid_input), .saturated(saturated)
);
`default_nettype wire

FILE: tb/tb_thermistor_resistance_to_celsius.sv
// Self-checking testbench for the Steinhart-Hart thermistor conversion block.
`timescale 1ns / 100ps
`default_nettype none
module tb_thermistor_resistance_to_celsius;
  import trc_pkg::*;

  localparam int RB = 22;
  localparam int LATENCY = 48;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic signed [15:0] temp;
    logic               inv;
    logic               sat;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [RB-1:0] resistance_ohms = '0;
  logic done;
  logic signed [15:0] temp_c_x100;
  logic invalid_input;
  logic saturated;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic [RB-1:0] sample_q[$];
  reading_t reading_q[$];
  logic [31:0] coef_a_m, coef_b_m, coef_c_m;
  logic hold_off = 1'b0;
  logic calm = 1'b0;
  int mismatches = 0;
  int samples_in = 0;
  int readings_out = 0;
  int sat_seen = 0;
  int inv_seen = 0;
  int quiet = 0;

  thermistor_resistance_to_celsius #(.RESIST_BITS(RB)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .resistance_ohms(resistance_ohms), .done(done), .temp_c_x100(temp_c_x100),
    .invalid_input(invalid_input), .saturated(saturated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Natural log in Q24 by normalizing and squaring out the log2 fraction bits.
  function automatic logic [63:0] ln_q24(input logic [63:0] r);
    int k;
    logic [63:0] m, lg;
    k = 31;
    while (k > 0 && r[k] == 1'b0) k--;
    m = (r << (31 - k)) & 64'hFFFF_FFFF;
    lg = '0;
    for (int i = 0; i < FRAC_BITS; i++) begin
      m = (m * m) >> 31;
      lg = lg << 1;
      if (m >= 64'h1_0000_0000) begin
        lg[0] = 1'b1;
        m = m >> 1;
      end
    end
    lg = lg | (64'(k) << FRAC_BITS);
    return (lg * 64'(LN2_Q30)) >> 34;
  endfunction

  function automatic reading_t celsius_of(input logic [RB-1:0] r);
    reading_t rd;
    logic [63:0] l, l2, l3, cterm, d;
    longint num, den, deg, t;
    rd.temp = '0;
    rd.inv = 1'b0;
    rd.sat = 1'b0;
    if (r == '0) begin
      rd.inv = 1'b1;
      return rd;
    end
    l = ln_q24(64'(r));
    l2 = (l * l) >> 24;
    l3 = (l2 * l) >> 24;
    cterm = (64'(coef_c_m) * (l3 >> 20) + ((64'(coef_c_m) * (l3 & 64'hF_FFFF)) >> 20)) >> 16;
    d = 64'(coef_a_m) + ((64'(coef_b_m) * l) >> 24) + cterm;
    if (d == 0) begin
      t = 32767;
      rd.sat = 1'b1;
    end else begin
      num = longint'(64'd100 << 40) - longint'(KELVIN_X100) * longint'(d);
      den = 100 * longint'(d);
      deg = num / den;
      t = deg * 100;
      if (t > 32767) begin
        t = 32767;
        rd.sat = 1'b1;
      end else if (t < -32768) begin
        t = -32768;
        rd.sat = 1'b1;
      end
    end
    rd.temp = t[15:0];
    return rd;
  endfunction

  // Driver: one beat per accepted start; the next sample is presented at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        reading_q.push_back(celsius_of(resistance_ohms));
        samples_in++;
      end
      if (sample_q.size() > 0 && !hold_off && (calm || $urandom_range(0, 99) >= 20)) begin
        start <= 1'b1;
        resistance_ohms <= sample_q.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor and stall watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        reading_t want;
        readings_out++;
        if (reading_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result beat: temp %0d", temp_c_x100);
        end else begin
          want = reading_q.pop_front();
          if (saturated) sat_seen++;
          if (invalid_input) inv_seen++;
          if (temp_c_x100 !== want.temp || invalid_input !== want.inv ||
              saturated !== want.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected temp %0d inv %0b sat %0b, got temp %0d inv %0b sat %0b",
                       want.temp, want.inv, want.sat, temp_c_x100, invalid_input, saturated);
          end
        end
      end
      if (done || (start && !busy)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic write_coef(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_A: coef_a_m = value;
      REG_B: coef_b_m = value;
      default: coef_c_m = value;
    endcase
  endtask

  task automatic set_coefs(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
    write_coef(REG_A, a);
    write_coef(REG_B, b);
    write_coef(REG_C, c);
  endtask

  task automatic drain();
    wait (sample_q.size() == 0);
    @(posedge clk);
    while (start || reading_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // Mostly log-spread resistances so that every range of temperature is reached.
  function automatic logic [RB-1:0] pick_resistance();
    int bits;
    logic [RB-1:0] v;
    v = RB'($urandom);
    if ($urandom_range(0, 49) == 0) return '0;
    if ($urandom_range(0, 3) == 0) return v;
    bits = $urandom_range(1, RB);
    return v & ((RB'(1) << bits) - 1'b1) | (RB'(1) << (bits - 1));
  endfunction

  task automatic random_samples(input int n);
    repeat (n) sample_q.push_back(pick_resistance());
  endtask

  initial begin
    coef_a_m = RESET_A;
    coef_b_m = RESET_B;
    coef_c_m = RESET_C;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Edge values of the resistance at the reset coefficients.
    foreach (sample_q[i]) ;
    sample_q.push_back('0);
    sample_q.push_back(RB'(1));
    sample_q.push_back(RB'(2));
    sample_q.push_back(RB'(3));
    sample_q.push_back(RB'(100));
    sample_q.push_back(RB'(1000));
    sample_q.push_back(RB'(10000));
    sample_q.push_back(RB'(100000));
    sample_q.push_back(RB'(1 << 21));
    sample_q.push_back({RB{1'b1}});
    sample_q.push_back(RB'(22'h155555));
    sample_q.push_back(RB'(22'h2AAAAA));
    random_samples(300);
    drain();

    // A zero denominator and clamping at the top of the range.
    set_coefs(32'd0, 32'd0, 32'd0);
    sample_q.push_back(RB'(1));
    sample_q.push_back(RB'(5000));
    sample_q.push_back('0);
    drain();
    set_coefs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    sample_q.push_back(RB'(1));
    sample_q.push_back({RB{1'b1}});
    random_samples(200);
    drain();
    set_coefs(32'd1, 32'd0, 32'd0);
    sample_q.push_back(RB'(1));
    random_samples(50);
    drain();

    set_coefs($urandom_range(RESET_A / 2, RESET_A * 2), $urandom_range(RESET_B / 2, RESET_B),
              $urandom_range(RESET_C / 2, RESET_C * 2));
    calm = 1'b1;
    random_samples(400);
    wait (sample_q.size() == 0);
    calm = 1'b0;
    drain();

    set_coefs($urandom, $urandom, $urandom);
    random_samples(200);
    drain();

    set_coefs(RESET_A, RESET_B, RESET_C);
    random_samples(250);
    // Pause the sender until the pipeline is empty, then carry on.
    wait (sample_q.size() < 120);
    hold_off = 1'b1;
    @(posedge clk);
    while (start || reading_q.size() != 0) @(posedge clk);
    hold_off = 1'b0;
    random_samples(300);
    drain();

    $display("Covered %0d samples and %0d result beats over six coefficient settings,",
             samples_in, readings_out);
    $display("with %0d saturated and %0d invalid readings.", sat_seen, inv_seen);
    if (mismatches == 0 && reading_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
